### sv/nfba_pkg.sv
// Shared types and constants of the next-fit block allocator.
// No dependencies; every other file imports this package.
package nfba_pkg;

	localparam int ZONE_W = 21;
	localparam int ADDR_W = 20;
	localparam int STATUS_W = 3;

	localparam logic [ZONE_W-1:0] ZONE_LOW = 21'd1024;
	localparam logic [ZONE_W-1:0] ZONE_HIGH = 21'd1048576;
	localparam logic [ZONE_W-1:0] ZONE_RESET = 21'd262144;

	// rounding: need = (req + header + TAIL_BYTES + ALIGN_ADD) & ~ALIGN_ADD
	localparam int TAIL_BYTES = 4;
	localparam int ALIGN_ADD = 7;

	localparam logic [STATUS_W-1:0] ST_OK = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NOFIT = 3'd1;
	localparam logic [STATUS_W-1:0] ST_UNKNOWN = 3'd2;
	localparam logic [STATUS_W-1:0] ST_DOUBLE = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FULL = 3'd4;

	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE = 1'b1;

	// register index decoded from paddr[2]
	localparam logic REG_ZONE = 1'b0;

	typedef enum logic [4:0] {
		S_INIT0,
		S_INIT1,
		S_IDLE,
		S_AROV,
		S_ASCAN,
		S_ANEWB,
		S_AFOUND,
		S_ASPLIT,
		S_AFIX,
		S_ABASE,
		S_FHEAD,
		S_FSCAN,
		S_FPREV,
		S_FPFIX,
		S_FNRD,
		S_FNEXT,
		S_FNFIX,
		S_RES
	} nfba_state_t;

	typedef struct packed {
		logic init;
		logic push;
		logic pop;
	} nfba_spare_cmd_t;

endpackage

### sv/nfba_req_if.sv
// Request channel of the allocator: valid/ready plus request payload.
// Depends on nfba_pkg for field widths.
interface nfba_req_if;
	import nfba_pkg::*;

	logic valid;
	logic ready;
	logic mode;
	logic [ADDR_W-1:0] req_bytes;
	logic [ADDR_W-1:0] block_addr;

	modport source (output valid, mode, req_bytes, block_addr, input ready);
	modport sink (input valid, mode, req_bytes, block_addr, output ready);
endinterface

### sv/nfba_rsp_if.sv
// Response channel of the allocator: valid/ready plus result payload.
// Depends on nfba_pkg for field widths.
interface nfba_rsp_if;
	import nfba_pkg::*;

	logic valid;
	logic ready;
	logic [ADDR_W-1:0] addr;
	logic [STATUS_W-1:0] status;

	modport source (output valid, addr, status, input ready);
	modport sink (input valid, addr, status, output ready);
endinterface

### sv/nfba_spare.sv
// Stack of unused block-table slots, held in a synchronous memory.
// Depends on nfba_pkg; entries below the low mark read as their initial slot.
module nfba_spare #(
	parameter int MAX_BLOCKS = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  nfba_pkg::nfba_spare_cmd_t       cmd,
	input  logic [$clog2(MAX_BLOCKS)-1:0]   push_slot,
	output logic [$clog2(MAX_BLOCKS)-1:0]   pop_slot,
	output logic                            empty
);
	import nfba_pkg::*;

	localparam int SLOT_W = $clog2(MAX_BLOCKS);
	localparam logic [SLOT_W-1:0] INIT_COUNT = SLOT_W'(MAX_BLOCKS - 2);

	logic [SLOT_W-1:0] spare_mem [MAX_BLOCKS];
	logic [SLOT_W-1:0] count_q;
	logic [SLOT_W-1:0] low_q;
	logic [SLOT_W-1:0] rd_s1;
	logic [SLOT_W-1:0] idx_s1;
	logic [SLOT_W-1:0] top_idx;

	assign top_idx = count_q - 1'b1;
	assign empty = (count_q == '0);

	// entries never written since init hold slot index + 2
	assign pop_slot = (idx_s1 < low_q) ? idx_s1 + SLOT_W'(2) : rd_s1;

	// track depth and the lowest index written since init
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= INIT_COUNT;
			low_q <= INIT_COUNT;
		end else if (cmd.init) begin
			count_q <= INIT_COUNT;
			low_q <= INIT_COUNT;
		end else if (cmd.push) begin
			count_q <= count_q + 1'b1;
			if (count_q < low_q) begin
				low_q <= count_q;
			end
		end else if (cmd.pop) begin
			count_q <= top_idx;
		end
	end

	// write pushed slot, read top on pop
	always_ff @(posedge clk) begin
		if (cmd.push && !cmd.init) begin
			spare_mem[count_q] <= push_slot;
		end
		if (cmd.pop) begin
			rd_s1 <= spare_mem[top_idx];
			idx_s1 <= top_idx;
		end
	end

`ifndef ASSERT_OFF
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> !empty) else $error("pop from empty spare stack");
	a_no_push_pop: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.push && cmd.pop)) else $error("push and pop in one cycle");
	a_pop_depth: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop && !cmd.init |=> count_q == $past(count_q) - 1'b1)
		else $error("pop did not lower depth");
`endif
endmodule

### sv/next_fit_block_allocator.sv
// Next-fit block allocator with coalescing over one zone, block table in memory.
// Depends on nfba_pkg, nfba_req_if, nfba_rsp_if and nfba_spare.
//
//  channel  dir  handshake         payload
//  req      in   valid/ready       mode, req_bytes, block_addr
//  rsp      out  valid/ready       addr, status
//  apb      in   psel/penable      paddr, pwdata -> prdata (zone_bytes)
//
// Alloc: the rover is read and latched as stop and first base; the scan visits a
// free block in S_ASCAN, a used one in S_ASCAN then S_ANEWB; a fit commits in
// S_AFOUND, or with a split in S_AFOUND, S_ASPLIT, S_AFIX and S_ABASE. Free:
// S_FHEAD reads the list head, S_FSCAN walks from it, S_FPREV to S_FNFIX merge.
// Both post the response in S_RES. The table's single read port sets this order.
// Reset or a zone_bytes write rebuilds the table; req is held off meanwhile.
// A response waits in its output register; a new request is taken meanwhile.
module next_fit_block_allocator #(
	parameter int MAX_BLOCKS = 1024,
	parameter int HEADER_BYTES = 24,
	parameter int MIN_FRAGMENT = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	nfba_req_if.sink    req,
	nfba_rsp_if.source  rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import nfba_pkg::*;

	localparam int SLOT_W = $clog2(MAX_BLOCKS);
	localparam int GD_W = SLOT_W + 2;

	typedef struct packed {
		logic [ZONE_W-1:0] start;
		logic [ZONE_W-1:0] size;
		logic              used;
		logic [SLOT_W-1:0] next;
		logic [SLOT_W-1:0] prev;
	} entry_t;

	entry_t tbl_mem [MAX_BLOCKS];
	entry_t tbl_rdata;
	entry_t tbl_wdata;
	logic [SLOT_W-1:0] tbl_raddr, tbl_waddr;
	logic tbl_we;

	nfba_state_t state_q, state_d;
	logic [ZONE_W-1:0] zone_q, zone_wr;
	logic [SLOT_W-1:0] rover_q, rover_d;
	logic [ZONE_W-1:0] need_q, need_d, need_calc, extra;
	logic [ADDR_W-1:0] uaddr_q, uaddr_d;
	logic [SLOT_W-1:0] cur_q, cur_d, stop_q, stop_d, base_q, base_d;
	logic [SLOT_W-1:0] b_q, b_d, nx_q, nx_d, s_q, s_d;
	entry_t base_e_q, base_e_d, be_q, be_d, merged;
	logic [GD_W-1:0] guard_q, guard_d;
	logic [ADDR_W-1:0] res_addr_q, res_addr_d;
	logic [STATUS_W-1:0] res_status_q, res_status_d;
	logic out_valid_q, out_load;
	logic [ADDR_W-1:0] out_addr_q;
	logic [STATUS_W-1:0] out_status_q;
	logic cfg_wr, base_fits, cand_fits, addr_hit;

	nfba_spare_cmd_t spare_cmd;
	logic [SLOT_W-1:0] spare_push_slot, spare_pop_slot;
	logic spare_empty;

	nfba_spare #(.MAX_BLOCKS(MAX_BLOCKS)) u_spare (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (spare_cmd),
		.push_slot (spare_push_slot),
		.pop_slot  (spare_pop_slot),
		.empty     (spare_empty)
	);

	// config port
	assign pready = 1'b1;
	assign prdata = {{(32-ZONE_W){1'b0}}, zone_q};
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_ZONE);

	always_comb begin
		zone_wr = pwdata[ZONE_W-1:0];
		if (zone_wr < ZONE_LOW) begin
			zone_wr = ZONE_LOW;
		end else if (zone_wr > ZONE_HIGH) begin
			zone_wr = ZONE_HIGH;
		end
	end

	// size with header and tail, aligned to 8
	assign need_calc = ({1'b0, req.req_bytes} + ZONE_W'(HEADER_BYTES + TAIL_BYTES + ALIGN_ADD))
		& ~ZONE_W'(ALIGN_ADD);
	assign extra = base_e_q.size - need_q;
	assign base_fits = !base_e_q.used && (base_e_q.size >= need_q);
	assign cand_fits = !tbl_rdata.used && (tbl_rdata.size >= need_q);
	assign addr_hit = ({1'b0, tbl_rdata.start} + (ZONE_W+1)'(HEADER_BYTES))
		== {2'b00, uaddr_q};

	// block table memory
	always_ff @(posedge clk) begin
		if (tbl_we) begin
			tbl_mem[tbl_waddr] <= tbl_wdata;
		end
		tbl_rdata <= tbl_mem[tbl_raddr];
	end

	// sequencer: next state, table and stack accesses
	always_comb begin
		state_d = state_q;
		rover_d = rover_q;
		need_d = need_q;
		uaddr_d = uaddr_q;
		cur_d = cur_q;
		stop_d = stop_q;
		base_d = base_q;
		base_e_d = base_e_q;
		be_d = be_q;
		b_d = b_q;
		nx_d = nx_q;
		s_d = s_q;
		guard_d = guard_q;
		res_addr_d = res_addr_q;
		res_status_d = res_status_q;
		tbl_raddr = '0;
		tbl_we = 1'b0;
		tbl_waddr = '0;
		tbl_wdata = '0;
		spare_cmd = '0;
		spare_push_slot = '0;
		merged = be_q;
		req.ready = 1'b0;
		out_load = 1'b0;

		case (state_q)
			S_INIT0: begin
				tbl_we = 1'b1;
				tbl_waddr = '0;
				tbl_wdata = '{start: zone_q, size: '0, used: 1'b1,
					next: SLOT_W'(1), prev: SLOT_W'(1)};
				spare_cmd.init = 1'b1;
				state_d = S_INIT1;
			end
			S_INIT1: begin
				tbl_we = 1'b1;
				tbl_waddr = SLOT_W'(1);
				tbl_wdata = '{start: '0, size: zone_q, used: 1'b0, next: '0, prev: '0};
				rover_d = SLOT_W'(1);
				state_d = S_IDLE;
			end
			S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					need_d = need_calc;
					uaddr_d = req.block_addr;
					if (req.mode == MODE_FREE) begin
						tbl_raddr = '0;
						state_d = S_FHEAD;
					end else begin
						tbl_raddr = rover_q;
						state_d = S_AROV;
					end
				end
			end
			// latch stop and first base, reread the rover
			S_AROV: begin
				stop_d = tbl_rdata.prev;
				base_d = rover_q;
				base_e_d = tbl_rdata;
				cur_d = rover_q;
				guard_d = '0;
				tbl_raddr = rover_q;
				state_d = S_ASCAN;
			end
			S_ASCAN: begin
				if (cur_q == stop_q) begin
					res_addr_d = '0;
					res_status_d = ST_NOFIT;
					state_d = S_RES;
				end else if (tbl_rdata.used) begin
					cur_d = tbl_rdata.next;
					base_d = tbl_rdata.next;
					tbl_raddr = tbl_rdata.next;
					state_d = S_ANEWB;
				end else if (base_fits) begin
					state_d = S_AFOUND;
				end else if (guard_q >= GD_W'(2 * MAX_BLOCKS)) begin
					res_addr_d = '0;
					res_status_d = ST_NOFIT;
					state_d = S_RES;
				end else begin
					guard_d = guard_q + 1'b1;
					cur_d = tbl_rdata.next;
					tbl_raddr = tbl_rdata.next;
				end
			end
			// new base after a used block
			S_ANEWB: begin
				base_e_d = tbl_rdata;
				if (cand_fits) begin
					state_d = S_AFOUND;
				end else if (guard_q >= GD_W'(2 * MAX_BLOCKS)) begin
					res_addr_d = '0;
					res_status_d = ST_NOFIT;
					state_d = S_RES;
				end else begin
					guard_d = guard_q + 1'b1;
					tbl_raddr = cur_q;
					state_d = S_ASCAN;
				end
			end
			S_AFOUND: begin
				if (extra > ZONE_W'(MIN_FRAGMENT)) begin
					if (spare_empty) begin
						res_addr_d = '0;
						res_status_d = ST_FULL;
						state_d = S_RES;
					end else begin
						spare_cmd.pop = 1'b1;
						state_d = S_ASPLIT;
					end
				end else begin
					tbl_we = 1'b1;
					tbl_waddr = base_q;
					tbl_wdata = base_e_q;
					tbl_wdata.used = 1'b1;
					rover_d = base_e_q.next;
					res_addr_d = ADDR_W'(base_e_q.start + ZONE_W'(HEADER_BYTES));
					res_status_d = ST_OK;
					state_d = S_RES;
				end
			end
			// write the remainder block, fetch the follower
			S_ASPLIT: begin
				s_d = spare_pop_slot;
				tbl_we = 1'b1;
				tbl_waddr = spare_pop_slot;
				tbl_wdata = '{start: base_e_q.start + need_q, size: extra, used: 1'b0,
					next: base_e_q.next, prev: base_q};
				tbl_raddr = base_e_q.next;
				state_d = S_AFIX;
			end
			S_AFIX: begin
				tbl_we = 1'b1;
				tbl_waddr = base_e_q.next;
				tbl_wdata = tbl_rdata;
				tbl_wdata.prev = s_q;
				state_d = S_ABASE;
			end
			S_ABASE: begin
				tbl_we = 1'b1;
				tbl_waddr = base_q;
				tbl_wdata = base_e_q;
				tbl_wdata.size = need_q;
				tbl_wdata.used = 1'b1;
				tbl_wdata.next = s_q;
				rover_d = s_q;
				res_addr_d = ADDR_W'(base_e_q.start + ZONE_W'(HEADER_BYTES));
				res_status_d = ST_OK;
				state_d = S_RES;
			end
			S_FHEAD: begin
				b_d = tbl_rdata.next;
				guard_d = '0;
				tbl_raddr = tbl_rdata.next;
				state_d = S_FSCAN;
			end
			// walk the list from the head looking for the offset
			S_FSCAN: begin
				if (b_q == '0) begin
					res_addr_d = '0;
					res_status_d = ST_UNKNOWN;
					state_d = S_RES;
				end else if (addr_hit) begin
					be_d = tbl_rdata;
					be_d.used = 1'b0;
					if (!tbl_rdata.used) begin
						res_addr_d = '0;
						res_status_d = ST_DOUBLE;
						state_d = S_RES;
					end else begin
						tbl_raddr = tbl_rdata.prev;
						state_d = S_FPREV;
					end
				end else if (guard_q >= GD_W'(MAX_BLOCKS)) begin
					res_addr_d = '0;
					res_status_d = ST_UNKNOWN;
					state_d = S_RES;
				end else begin
					b_d = tbl_rdata.next;
					guard_d = guard_q + 1'b1;
					tbl_raddr = tbl_rdata.next;
				end
			end
			// merge into a free predecessor, or go on to the successor
			S_FPREV: begin
				if (!tbl_rdata.used) begin
					merged = tbl_rdata;
					merged.size = tbl_rdata.size + be_q.size;
					merged.next = be_q.next;
					tbl_we = 1'b1;
					tbl_waddr = be_q.prev;
					tbl_wdata = merged;
					if (rover_q == b_q) begin
						rover_d = be_q.prev;
					end
					spare_cmd.push = 1'b1;
					spare_push_slot = b_q;
					be_d = merged;
					b_d = be_q.prev;
					nx_d = be_q.next;
					tbl_raddr = be_q.next;
					state_d = S_FPFIX;
				end else begin
					tbl_raddr = be_q.next;
					state_d = S_FNEXT;
				end
			end
			S_FPFIX: begin
				tbl_we = 1'b1;
				tbl_waddr = nx_q;
				tbl_wdata = tbl_rdata;
				tbl_wdata.prev = b_q;
				state_d = S_FNRD;
			end
			S_FNRD: begin
				tbl_raddr = be_q.next;
				state_d = S_FNEXT;
			end
			// merge a free successor, then write the block back
			S_FNEXT: begin
				tbl_we = 1'b1;
				tbl_waddr = b_q;
				if (!tbl_rdata.used) begin
					merged = be_q;
					merged.size = be_q.size + tbl_rdata.size;
					merged.next = tbl_rdata.next;
					tbl_wdata = merged;
					if (rover_q == be_q.next) begin
						rover_d = b_q;
					end
					spare_cmd.push = 1'b1;
					spare_push_slot = be_q.next;
					nx_d = tbl_rdata.next;
					tbl_raddr = tbl_rdata.next;
					state_d = S_FNFIX;
				end else begin
					tbl_wdata = be_q;
					res_addr_d = '0;
					res_status_d = ST_OK;
					state_d = S_RES;
				end
			end
			S_FNFIX: begin
				tbl_we = 1'b1;
				tbl_waddr = nx_q;
				tbl_wdata = tbl_rdata;
				tbl_wdata.prev = b_q;
				res_addr_d = '0;
				res_status_d = ST_OK;
				state_d = S_RES;
			end
			// hand the result to the output register when it is free
			S_RES: begin
				if (!out_valid_q || rsp.ready) begin
					out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_INIT0;
			end
		endcase

		if (cfg_wr) begin
			state_d = S_INIT0;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT0;
			zone_q <= ZONE_RESET;
			rover_q <= SLOT_W'(1);
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rover_q <= rover_d;
			if (cfg_wr) begin
				zone_q <= zone_wr;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working and payload registers
	always_ff @(posedge clk) begin
		need_q <= need_d;
		uaddr_q <= uaddr_d;
		cur_q <= cur_d;
		stop_q <= stop_d;
		base_q <= base_d;
		base_e_q <= base_e_d;
		be_q <= be_d;
		b_q <= b_d;
		nx_q <= nx_d;
		s_q <= s_d;
		guard_q <= guard_d;
		res_addr_q <= res_addr_d;
		res_status_q <= res_status_d;
		if (out_load) begin
			out_addr_q <= res_addr_q;
			out_status_q <= res_status_q;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.addr = out_addr_q;
	assign rsp.status = out_status_q;

`ifndef ASSERT_OFF
	a_cfg_reinit: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> state_q == S_INIT0) else $error("zone write did not rebuild table");
	a_err_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status != ST_OK |-> rsp.addr == '0)
		else $error("error response with nonzero addr");
	a_req_starts: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready && !cfg_wr |=> state_q != S_IDLE)
		else $error("accepted request not started");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> !out_valid_q || rsp.ready)
		else $error("response overwritten");
`endif
endmodule

### verif/next_fit_block_allocator_tb.sv
// Self-checking bench for the next-fit block allocator: random and directed
// allocate/free requests checked against an in-bench model of the block table.
// Depends on nfba_pkg, nfba_req_if, nfba_rsp_if and the allocator RTL.
module next_fit_block_allocator_tb;
	import nfba_pkg::*;

	localparam int NBLK = 1024;
	localparam int HDR = 24;
	localparam int MINFRAG = 64;

	typedef struct packed {
		logic mode;
		logic [ADDR_W-1:0] req_bytes;
		logic [ADDR_W-1:0] block_addr;
	} alloc_req_t;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [STATUS_W-1:0] status;
	} alloc_rsp_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	nfba_req_if req_ch ();
	nfba_rsp_if rsp_ch ();

	next_fit_block_allocator u_dut (
		.clk(clk), .arst_n(arst_n), .req(req_ch.sink), .rsp(rsp_ch.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Block table model
	int unsigned m_start[NBLK];
	int unsigned m_size[NBLK];
	bit m_used[NBLK];
	int unsigned m_next[NBLK];
	int unsigned m_prev[NBLK];
	int unsigned m_spare[NBLK];
	int unsigned m_spare_cnt;
	int unsigned m_rover;
	int unsigned m_zone;

	alloc_req_t pending_reqs[$];
	alloc_rsp_t expected_rsps[$];
	int unsigned live_addrs[$];
	int errors;

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic void table_init();
		m_start[0] = m_zone; m_size[0] = 0; m_used[0] = 1;
		m_next[0] = 1; m_prev[0] = 1;
		m_start[1] = 0; m_size[1] = m_zone; m_used[1] = 0;
		m_next[1] = 0; m_prev[1] = 0;
		m_rover = 1;
		m_spare_cnt = 0;
		for (int i = 2; i < NBLK; i++) begin
			m_spare[m_spare_cnt] = i;
			m_spare_cnt++;
		end
	endfunction

	function automatic void zone_write(int unsigned v);
		v = v & 32'h1FFFFF;
		if (v < ZONE_LOW) v = ZONE_LOW;
		if (v > ZONE_HIGH) v = ZONE_HIGH;
		m_zone = v;
		table_init();
	endfunction

	function automatic void slot_release(int unsigned s);
		if (m_spare_cnt < NBLK) begin
			m_spare[m_spare_cnt] = s;
			m_spare_cnt++;
		end
	endfunction

	function automatic alloc_rsp_t predict_alloc(int unsigned nbytes);
		alloc_rsp_t r;
		int unsigned need, base, cur, stop, guard, extra, s;
		r = '0;
		need = (nbytes + HDR + 4 + 7) & ~32'd7;
		base = m_rover;
		cur = m_rover;
		stop = m_prev[m_rover];
		guard = 0;
		forever begin
			if (cur == stop) begin
				r.status = ST_NOFIT;
				return r;
			end
			if (m_used[cur]) begin
				cur = m_next[cur];
				base = cur;
			end else begin
				cur = m_next[cur];
			end
			if (!m_used[base] && m_size[base] >= need) break;
			guard++;
			if (guard > 2 * NBLK) begin
				r.status = ST_NOFIT;
				return r;
			end
		end
		extra = m_size[base] - need;
		if (extra > MINFRAG) begin
			if (m_spare_cnt == 0) begin
				r.status = ST_FULL;
				return r;
			end
			m_spare_cnt--;
			s = m_spare[m_spare_cnt];
			m_start[s] = m_start[base] + need;
			m_size[s] = extra;
			m_used[s] = 0;
			m_prev[s] = base;
			m_next[s] = m_next[base];
			m_prev[m_next[s]] = s;
			m_next[base] = s;
			m_size[base] = need;
		end
		m_used[base] = 1;
		m_rover = m_next[base];
		r.addr = ADDR_W'(m_start[base] + HDR);
		r.status = ST_OK;
		return r;
	endfunction

	function automatic alloc_rsp_t predict_free(int unsigned uaddr);
		alloc_rsp_t r;
		int unsigned b, guard, other;
		r = '0;
		b = m_next[0];
		guard = 0;
		while (b != 0) begin
			if (m_start[b] + HDR == uaddr) break;
			b = m_next[b];
			guard++;
			if (guard > NBLK) begin
				r.status = ST_UNKNOWN;
				return r;
			end
		end
		if (b == 0) begin
			r.status = ST_UNKNOWN;
			return r;
		end
		if (!m_used[b]) begin
			r.status = ST_DOUBLE;
			return r;
		end
		m_used[b] = 0;
		// merge with the lower neighbor
		other = m_prev[b];
		if (!m_used[other]) begin
			m_size[other] += m_size[b];
			m_next[other] = m_next[b];
			m_prev[m_next[other]] = other;
			if (m_rover == b) m_rover = other;
			slot_release(b);
			b = other;
		end
		// merge with the upper neighbor
		other = m_next[b];
		if (!m_used[other]) begin
			m_size[b] += m_size[other];
			m_next[b] = m_next[other];
			m_prev[m_next[b]] = b;
			if (m_rover == other) m_rover = b;
			slot_release(other);
		end
		r.status = ST_OK;
		return r;
	endfunction

	function automatic int unsigned gap_len();
		int unsigned p;
		p = $urandom_range(0, 99);
		if (p < 45) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Request driver
	int unsigned drv_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.mode <= MODE_ALLOC;
			req_ch.req_bytes <= '0;
			req_ch.block_addr <= '0;
			drv_gap <= 0;
		end else begin
			alloc_req_t it;
			if (req_ch.valid && req_ch.ready) begin
				it = pending_reqs.pop_front();
				if (it.mode == MODE_ALLOC)
					expected_rsps.push_back(predict_alloc(it.req_bytes));
				else
					expected_rsps.push_back(predict_free(it.block_addr));
			end
			if (req_ch.valid && !req_ch.ready) begin
				// hold the request until accepted
			end else if (drv_gap != 0) begin
				req_ch.valid <= 1'b0;
				drv_gap <= drv_gap - 1;
			end else if ((req_ch.valid && req_ch.ready ? pending_reqs.size() > 0 :
					pending_reqs.size() > 0) && !psel) begin
				it = pending_reqs[0];
				req_ch.valid <= 1'b1;
				req_ch.mode <= it.mode;
				req_ch.req_bytes <= it.req_bytes;
				req_ch.block_addr <= it.block_addr;
				drv_gap <= gap_len();
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// Response monitor with random back-pressure
	int unsigned mon_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			mon_gap <= 0;
		end else begin
			alloc_rsp_t exp_r;
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_rsps.size() == 0) begin
					$error("unexpected response addr=%0h status=%0d",
						rsp_ch.addr, rsp_ch.status);
					errors++;
				end else begin
					exp_r = expected_rsps.pop_front();
					if (rsp_ch.addr !== exp_r.addr) begin
						$error("addr: expected %0h actual %0h", exp_r.addr, rsp_ch.addr);
						errors++;
					end
					if (rsp_ch.status !== exp_r.status) begin
						$error("status: expected %0d actual %0d", exp_r.status,
							rsp_ch.status);
						errors++;
					end
					if (exp_r.status == ST_OK && exp_r.addr != 0)
						live_addrs.push_back(exp_r.addr);
				end
			end
			if (mon_gap != 0) begin
				rsp_ch.ready <= 1'b0;
				mon_gap <= mon_gap - 1;
			end else begin
				rsp_ch.ready <= 1'b1;
				mon_gap <= gap_len();
			end
		end
	end

	task automatic push_req(logic mode, int unsigned nbytes, int unsigned uaddr);
		alloc_req_t it;
		it.mode = mode;
		it.req_bytes = ADDR_W'(nbytes);
		it.block_addr = ADDR_W'(uaddr);
		pending_reqs.push_back(it);
	endtask

	// Wait until everything queued has been answered, then let the block settle
	task automatic drain();
		while (pending_reqs.size() != 0 || expected_rsps.size() != 0 || req_ch.valid)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic reg_write(int unsigned v);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= 3'd0; pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		zone_write(v);
		live_addrs.delete();
		repeat (4) @(posedge clk);
	endtask

	// Mostly allocations of small blocks and frees of live ones
	task automatic random_phase(int n, int unsigned zone);
		int unsigned p, k;
		for (int i = 0; i < n; i++) begin
			p = $urandom_range(0, 99);
			if (p < 48) begin
				if ($urandom_range(0, 19) == 0)
					push_req(MODE_ALLOC, $urandom(), 0);
				else
					push_req(MODE_ALLOC, $urandom_range(0, zone / 16), 0);
			end else if (p < 90 && live_addrs.size() > 0) begin
				k = $urandom_range(0, live_addrs.size() - 1);
				push_req(MODE_FREE, 0, live_addrs[k]);
				live_addrs.delete(k);
			end else begin
				push_req(MODE_FREE, $urandom(), $urandom_range(0, 3) == 0 ?
					$urandom() : ($urandom_range(0, zone) & ~32'd7) + HDR);
			end
			// keep the queue short so frees refer to answered allocations
			while (pending_reqs.size() > 4) @(posedge clk);
			if (live_addrs.size() == 0 && p >= 48) drain();
		end
		drain();
	endtask

	initial begin
		errors = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		arst_n = 1'b0;
		m_zone = ZONE_RESET;
		table_init();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (4) @(posedge clk);

		// Directed: extremes, no fit, double free, unknown address, merges
		push_req(MODE_ALLOC, 0, 0);
		push_req(MODE_ALLOC, 20'hFFFFF, 0);
		push_req(MODE_ALLOC, 100, 0);
		push_req(MODE_ALLOC, 40, 0);
		push_req(MODE_ALLOC, 262144 - 200, 0);
		push_req(MODE_FREE, 20'hFFFFF, HDR);
		push_req(MODE_FREE, 0, HDR);
		push_req(MODE_FREE, 0, 20'hFFFFF);
		push_req(MODE_FREE, 0, 0);
		push_req(MODE_FREE, 0, HDR + 32);
		push_req(MODE_FREE, 0, HDR + 32);
		drain();

		// Small zone (write below the low bound saturates), then the table limit
		reg_write(0);
		random_phase(100, 1024);
		reg_write(32'hFFFFFFFF);
		for (int i = 0; i < 1025; i++) push_req(MODE_ALLOC, 0, 0);
		push_req(MODE_FREE, 0, HDR + 32);
		push_req(MODE_ALLOC, 0, 0);
		drain();
		reg_write(4096);
		random_phase(150, 4096);
		reg_write(1048576);
		random_phase(150, 65536);
		reg_write(262144);
		random_phase(110, 262144);
		drain();
		if (errors == 0 && expected_rsps.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#40000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
